FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk_i edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

FILE: hw/rtl/lssp_pkg.sv
// ----------------------------------------------------------------------------
// lssp_pkg
// Types and constants of the linked stacks in a shared slot pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lssp_pkg;

  localparam int unsigned PoolDepthDef = 256;
  localparam int unsigned NumStacksDef = 8;
  localparam int unsigned DataWidthDef = 32;

  localparam int unsigned OpW        = 2;
  localparam int unsigned SidW       = 3;
  localparam int unsigned ValW       = 32;
  localparam int unsigned StatW      = 2;
  localparam int unsigned StackSlots = 2 ** SidW;

  typedef enum logic [OpW-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } opcode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/linked_stacks_shared_pool_core.sv
// ----------------------------------------------------------------------------
// linked_stacks_shared_pool_core
// Up to eight linked stacks sharing one pool of value slots.
//
// Input channel (in_valid_i / in_stall_o) carries opcode_i (push, pop,
// query), stack_id_i and push_value_i. Output channel (out_valid_o /
// out_stall_i) carries pop_value_o, stack_empty_o and status_o, one result
// per transaction, in order.
// A transaction is taken in the idle state, where the top pointer selects
// the slot memory read; the execute state then commits the update and
// loads the result register, and out_valid_o is registered from the commit.
// No new transaction is taken until the previous one has committed.
// A stalled result holds in its register; the next transaction is still
// taken and waits in its commit cycle until the register is free.
// Reset empties all stacks and the free-slot bookkeeping at once; no
// clearing pass is needed and the block takes a transaction right after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linked_stacks_shared_pool_core #(
  parameter int unsigned POOL_DEPTH = lssp_pkg::PoolDepthDef,
  parameter int unsigned NUM_STACKS = lssp_pkg::NumStacksDef,
  parameter int unsigned DATA_WIDTH = lssp_pkg::DataWidthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic        [lssp_pkg::OpW-1:0]   opcode_i,
  input  wire logic        [lssp_pkg::SidW-1:0]  stack_id_i,
  input  wire logic signed [lssp_pkg::ValW-1:0]  push_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed      [lssp_pkg::ValW-1:0]  pop_value_o,
  output logic                                   stack_empty_o,
  output logic             [lssp_pkg::StatW-1:0] status_o
);
  import lssp_pkg::*;

  cmd_t cmd;

  lssp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lssp_datapath #(
    .POOL_DEPTH (POOL_DEPTH),
    .NUM_STACKS (NUM_STACKS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .opcode_i      (opcode_i),
    .stack_id_i    (stack_id_i),
    .push_value_i  (push_value_i),
    .pop_value_o   (pop_value_o),
    .stack_empty_o (stack_empty_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lssp_ctrl.sv
// ----------------------------------------------------------------------------
// lssp_ctrl
// Sequencer: takes one transaction, runs its commit cycle, owns output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lssp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output lssp_pkg::cmd_t     cmd_o
);
  import lssp_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        // result register free or emptied this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd.commit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd.commit | (out_valid_q & out_stall_i);
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  `ASSERT_NEVER(a_cap_commit_excl, cmd.capture && cmd.commit, "capture and commit together")
  `ASSERT_CLK(a_cap_to_exec, cmd.capture |=> state_q == S_EXEC, "capture not followed by exec")
  `ASSERT_CLK(a_valid_from_commit, $rose(out_valid_q) |-> $past(cmd.commit), "valid without commit")

endmodule

`default_nettype wire

FILE: hw/rtl/lssp_datapath.sv
// ----------------------------------------------------------------------------
// lssp_datapath
// Slot memories, top pointers, returned-slot FIFO and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lssp_datapath #(
  parameter int unsigned POOL_DEPTH = lssp_pkg::PoolDepthDef,
  parameter int unsigned NUM_STACKS = lssp_pkg::NumStacksDef,
  parameter int unsigned DATA_WIDTH = lssp_pkg::DataWidthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire lssp_pkg::cmd_t                    cmd_i,
  input  wire logic        [lssp_pkg::OpW-1:0]   opcode_i,
  input  wire logic        [lssp_pkg::SidW-1:0]  stack_id_i,
  input  wire logic signed [lssp_pkg::ValW-1:0]  push_value_i,
  output logic signed      [lssp_pkg::ValW-1:0]  pop_value_o,
  output logic                                   stack_empty_o,
  output logic             [lssp_pkg::StatW-1:0] status_o
);
  import lssp_pkg::*;

  localparam int unsigned IdxW = $clog2(POOL_DEPTH);
  localparam int unsigned PtrW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned ExtW = (DATA_WIDTH > ValW) ? DATA_WIDTH : ValW;
  localparam logic [PtrW-1:0] NullPtr = PtrW'(POOL_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(POOL_DEPTH - 1);

  logic [DATA_WIDTH-1:0] val_mem  [POOL_DEPTH];
  logic [PtrW-1:0]       link_mem [POOL_DEPTH];
  logic [IdxW-1:0]       free_mem [POOL_DEPTH];

  logic [PtrW-1:0]       top_q [StackSlots];
  logic [IdxW-1:0]       fifo_rd_pos_q, fifo_wr_pos_q;
  logic [PtrW-1:0]       fifo_cnt_q, fresh_cnt_q;

  opcode_e               op_q;
  logic [SidW-1:0]       sid_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [DATA_WIDTH-1:0] val_rd_q;
  logic [PtrW-1:0]       link_rd_q;
  logic [IdxW-1:0]       free_rd_q;

  logic signed [ValW-1:0] pop_value_q;
  logic                   stack_empty_q;
  status_e                status_q;

  // capture-side read address
  logic [ExtW-1:0] push_ext;
  logic [PtrW-1:0] cap_top;
  logic [IdxW-1:0] rd_addr;

  assign push_ext = ExtW'($unsigned(push_value_i));
  assign cap_top  = (32'(stack_id_i) < NUM_STACKS) ? top_q[stack_id_i] : NullPtr;
  assign rd_addr  = (cap_top != NullPtr) ? cap_top[IdxW-1:0] : '0;

  // execute-side decision
  logic            valid_id, top_null, have_fifo, have_fresh;
  logic [PtrW-1:0] top_cur;
  logic [IdxW-1:0] push_slot;
  logic            push_ok, pop_ok, fifo_put, fifo_take;
  logic [ExtW-1:0] pop_ext;
  logic [ValW-1:0] res_value;
  logic            res_empty;
  status_e         res_status;

  always_comb begin
    valid_id   = 32'(sid_q) < NUM_STACKS;
    top_cur    = valid_id ? top_q[sid_q] : NullPtr;
    top_null   = top_cur == NullPtr;
    have_fifo  = fifo_cnt_q != '0;
    have_fresh = fresh_cnt_q != NullPtr;
    push_slot  = have_fifo ? free_rd_q : fresh_cnt_q[IdxW-1:0];
    pop_ext    = ExtW'(val_rd_q);
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    fifo_put   = 1'b0;
    fifo_take  = 1'b0;
    res_value  = '0;
    res_empty  = top_null;
    res_status = ST_OK;
    case (op_q)
      OP_PUSH: begin
        if (valid_id && (have_fifo || have_fresh)) begin
          push_ok   = 1'b1;
          fifo_take = have_fifo;
          res_empty = 1'b0;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_POP: begin
        if (!top_null) begin
          pop_ok    = 1'b1;
          fifo_put  = fifo_cnt_q != NullPtr;
          res_value = pop_ext[ValW-1:0];
          res_empty = link_rd_q >= NullPtr;
        end else begin
          res_status = ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= opcode_e'(opcode_i);
      sid_q     <= stack_id_i;
      val_q     <= push_ext[DATA_WIDTH-1:0];
      val_rd_q  <= val_mem[rd_addr];
      link_rd_q <= link_mem[rd_addr];
      free_rd_q <= free_mem[fifo_rd_pos_q];
    end
    if (cmd_i.commit && push_ok) begin
      val_mem[push_slot]  <= val_q;
      link_mem[push_slot] <= top_cur;
    end
    if (cmd_i.commit && fifo_put) begin
      free_mem[fifo_wr_pos_q] <= top_cur[IdxW-1:0];
    end
    if (cmd_i.commit) begin
      pop_value_q   <= $signed(res_value);
      stack_empty_q <= res_empty;
      status_q      <= res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StackSlots; i++) begin
        top_q[i] <= NullPtr;
      end
      fifo_rd_pos_q <= '0;
      fifo_wr_pos_q <= '0;
      fifo_cnt_q    <= '0;
      fresh_cnt_q   <= '0;
    end else if (cmd_i.commit) begin
      if (push_ok) begin
        top_q[sid_q] <= PtrW'(push_slot);
      end else if (pop_ok) begin
        top_q[sid_q] <= link_rd_q;
      end
      if (fifo_take) begin
        fifo_rd_pos_q <= (fifo_rd_pos_q == LastIdx) ? '0 : fifo_rd_pos_q + 1'b1;
        fifo_cnt_q    <= fifo_cnt_q - 1'b1;
      end else if (fifo_put) begin
        fifo_wr_pos_q <= (fifo_wr_pos_q == LastIdx) ? '0 : fifo_wr_pos_q + 1'b1;
        fifo_cnt_q    <= fifo_cnt_q + 1'b1;
      end
      if (push_ok && !have_fifo) begin
        fresh_cnt_q <= fresh_cnt_q + 1'b1;
      end
    end
  end

  assign pop_value_o   = pop_value_q;
  assign stack_empty_o = stack_empty_q;
  assign status_o      = status_q;

  `ASSERT_CLK(a_fifo_bound, fifo_cnt_q <= NullPtr, "returned-slot count above pool depth")
  `ASSERT_CLK(a_fresh_mono, fresh_cnt_q >= $past(fresh_cnt_q), "fresh slot count decreased")

endmodule

`default_nettype wire
